[sv/mbps_pkg.sv]
// ----------------------------------------------------------------------------
// Masked byte pattern search package
// Shared constants, register indexes and transaction payload types.
// ----------------------------------------------------------------------------
package mbps_pkg;

  localparam int MAX_PATTERN    = 16;
  localparam int OFFSET_BITS    = 32;
  localparam int POS_BITS       = $clog2(MAX_PATTERN);
  localparam int LEN_BITS       = 5;
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 64;
  localparam int BYTE_BITS      = 8;

  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LOW  = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_HIGH = 8'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CARE_MASK    = 8'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LEN  = 8'd3;

  localparam logic [LEN_BITS-1:0] PATTERN_LEN_RESET = 5'd1;

  typedef logic [BYTE_BITS-1:0] byte_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic        match_now;
    logic [31:0] match_offset;
  } out_item_t;

endpackage

[sv/masked_byte_pattern_search_core.sv]
// ----------------------------------------------------------------------------
// Masked byte pattern search core
// The result of an accepted input transaction is registered and valid in the cycle after it is accepted.
// Throughput: one byte per cycle while the output is not stalled; the masked window compare is a single stage.
// Reset: clears window, byte count, found mark, config (length 1) and output valid.
// ----------------------------------------------------------------------------
module masked_byte_pattern_search_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  mbps_pkg::in_item_t                     in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output mbps_pkg::out_item_t                    out_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [mbps_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [mbps_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
  import mbps_pkg::*;

  logic [63:0]             pattern_low;
  logic [63:0]             pattern_high;
  logic [127:0]            pattern_all;
  logic [MAX_PATTERN-1:0]  care_mask;
  logic [LEN_BITS-1:0]     pattern_len;

  byte_t                   window [MAX_PATTERN];
  byte_t                   window_next [MAX_PATTERN];
  logic [OFFSET_BITS-1:0]  bytes_seen;
  logic [OFFSET_BITS-1:0]  bytes_seen_next;
  logic [OFFSET_BITS-1:0]  seen_base;
  logic                    found;
  logic                    found_base;

  byte_t                   pat_arr [MAX_PATTERN];
  logic [LEN_BITS-1:0]     len_used;
  logic [OFFSET_BITS-1:0]  offset;
  logic                    any_care;
  logic                    all_eq;
  logic                    hit;
  logic                    in_accept;
  out_item_t               result;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  assign pattern_all = {pattern_high, pattern_low};

  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      pat_arr[k] = pattern_all[BYTE_BITS*k +: BYTE_BITS];
    end
  end

  // Length zero behaves as one, anything past the window as the full window.
  always_comb begin
    if (pattern_len == '0) begin
      len_used = LEN_BITS'(1);
    end else if (pattern_len > LEN_BITS'(MAX_PATTERN)) begin
      len_used = LEN_BITS'(MAX_PATTERN);
    end else begin
      len_used = pattern_len;
    end
  end

  // A restart clears the history before the new byte is shifted in.
  always_comb begin
    window_next[0] = in_data.data_byte;
    for (int j = 1; j < MAX_PATTERN; j++) begin
      window_next[j] = in_data.restart ? '0 : window[j-1];
    end
    seen_base  = in_data.restart ? '0 : bytes_seen;
    found_base = in_data.restart ? 1'b0 : found;
    bytes_seen_next = (seen_base == '1) ? seen_base : seen_base + 1'b1;
  end

  // Window entry j lines up with pattern position len_used - 1 - j.
  always_comb begin
    logic [LEN_BITS-1:0] pos;
    logic                lane_on;
    any_care = 1'b0;
    all_eq   = 1'b1;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      pos     = len_used - LEN_BITS'(1) - LEN_BITS'(j);
      lane_on = (LEN_BITS'(j) < len_used) && care_mask[pos[POS_BITS-1:0]];
      if (lane_on) begin
        any_care = 1'b1;
        if (window_next[j] != pat_arr[pos[POS_BITS-1:0]]) begin
          all_eq = 1'b0;
        end
      end
    end
  end

  assign hit = !found_base && any_care && all_eq &&
               (bytes_seen_next >= OFFSET_BITS'(len_used));
  assign offset = bytes_seen_next - OFFSET_BITS'(len_used);

  always_comb begin
    result.match_now    = hit;
    result.match_offset = hit ? 32'(offset) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low  <= '0;
      pattern_high <= '0;
      care_mask    <= '0;
      pattern_len  <= PATTERN_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PATTERN_LOW:  pattern_low  <= cfg_data;
        REG_PATTERN_HIGH: pattern_high <= cfg_data;
        REG_CARE_MASK:    care_mask    <= cfg_data[MAX_PATTERN-1:0];
        REG_PATTERN_LEN:  pattern_len  <= cfg_data[LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
        window[j] <= '0;
      end
      bytes_seen <= '0;
      found      <= 1'b0;
    end else if (in_accept) begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
        window[j] <= window_next[j];
      end
      bytes_seen <= bytes_seen_next;
      found      <= found_base || hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data <= result;
    end
  end

  // Once found, bytes of the same image never report another match.
  a_single_match: assert property (@(posedge clk) disable iff (rst)
    (in_accept && found && !in_data.restart) |=> !out_data.match_now)
    else $error("second match reported without restart");

  // A reported match that is still held must agree with the found mark.
  a_match_found: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.match_now) |-> found)
    else $error("match reported but found mark clear");

  // Every accepted byte is counted.
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (bytes_seen != '0) && out_valid)
    else $error("accepted byte not counted");

endmodule

[verif/tb_masked_byte_pattern_search_core.sv]
// ----------------------------------------------------------------------------
// Masked byte pattern search core testbench
// Streams byte images through the core under random flow control, predicts
// the first masked match of each image and checks every result in order.
// ----------------------------------------------------------------------------
module tb_masked_byte_pattern_search_core;
  import mbps_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SCAN_PHASES = 30;
  localparam int PHASE_BYTES = 48;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // Predictor state, updated only from observed transactions.
  logic [63:0] scan_low;
  logic [63:0] scan_high;
  logic [15:0] scan_mask;
  logic [LEN_BITS-1:0] scan_len;
  byte_t scan_window [MAX_PATTERN];
  logic [OFFSET_BITS-1:0] scan_seen;
  logic scan_found;
  out_item_t search_results_due[$];

  // Pattern as last programmed, used to build images that should match.
  logic [63:0] cur_low;
  logic [63:0] cur_high;
  logic [15:0] cur_mask;
  logic [LEN_BITS-1:0] cur_len;

  int send_idle_pct;
  int recv_idle_pct;
  int error_count = 0;
  int bytes_sent = 0;
  int cycle_count = 0;

  masked_byte_pattern_search_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_masked_byte_pattern_search_core failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic int clamp_len(input logic [LEN_BITS-1:0] len);
    if (len == 0) return 1;
    if (len > MAX_PATTERN) return MAX_PATTERN;
    return len;
  endfunction

  function automatic byte_t pattern_at(input logic [63:0] low, input logic [63:0] high,
                                       input int k);
    return (k < 8) ? low[8*k +: 8] : high[8*(k-8) +: 8];
  endfunction

  function automatic void clear_scan_state();
    int k;
    for (k = 0; k < MAX_PATTERN; k++) scan_window[k] = '0;
    scan_seen = '0;
    scan_found = 1'b0;
  endfunction

  // Shifts one byte into the window and returns the result it produces.
  function automatic out_item_t scan_step(input in_item_t item);
    int span;
    int k;
    logic any_care;
    logic all_equal;
    out_item_t res;
    span = clamp_len(scan_len);
    any_care = 1'b0;
    all_equal = 1'b1;
    res = '0;
    if (item.restart) clear_scan_state();
    for (k = MAX_PATTERN - 1; k > 0; k--) scan_window[k] = scan_window[k - 1];
    scan_window[0] = item.data_byte;
    if (scan_seen != '1) scan_seen++;
    // Pattern byte k lines up with the k-th oldest of the newest span bytes.
    for (k = 0; k < span; k++) begin
      if (scan_mask[k]) begin
        any_care = 1'b1;
        if (scan_window[span - 1 - k] != pattern_at(scan_low, scan_high, k)) begin
          all_equal = 1'b0;
        end
      end
    end
    if (!scan_found && any_care && all_equal && scan_seen >= OFFSET_BITS'(span)) begin
      scan_found = 1'b1;
      res.match_now = 1'b1;
      res.match_offset = scan_seen - OFFSET_BITS'(span);
    end
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      clear_scan_state();
      scan_low = '0;
      scan_high = '0;
      scan_mask = '0;
      scan_len = PATTERN_LEN_RESET;
      search_results_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PATTERN_LOW: begin
            scan_low = cfg_data;
          end
          REG_PATTERN_HIGH: begin
            scan_high = cfg_data;
          end
          REG_CARE_MASK: begin
            scan_mask = cfg_data[15:0];
          end
          REG_PATTERN_LEN: begin
            scan_len = cfg_data[LEN_BITS-1:0];
          end
          default: begin
          end
        endcase
      end
      if (in_valid && in_ready) begin
        search_results_due.insert(search_results_due.size(), scan_step(in_data));
      end
      if (out_valid && out_ready) begin
        if (search_results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
          error_count++;
        end else begin
          want = search_results_due.pop_front();
          if (out_data.match_now !== want.match_now) begin
            $display("%0t: match_now expected %b, actual %b", $time, want.match_now,
                     out_data.match_now);
            error_count++;
          end
          if (out_data.match_offset !== want.match_offset) begin
            $display("%0t: match_offset expected %0d, actual %0d", $time,
                     want.match_offset, out_data.match_offset);
            error_count++;
          end
        end
      end
    end
  end

  task automatic set_idle(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // The valid is left high on return so back-to-back bytes need no gap.
  task automatic send_byte(input byte_t value, input logic restart_flag);
    in_item_t item;
    item.data_byte = value;
    item.restart = restart_flag;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (search_results_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic [63:0] low, input logic [63:0] high,
                           input logic [15:0] mask, input logic [LEN_BITS-1:0] len);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    drain();
    cur_low = low;
    cur_high = high;
    cur_mask = mask;
    cur_len = len;
    write_reg(REG_PATTERN_LOW, low);
    write_reg(REG_PATTERN_HIGH, high);
    // Bits above each field are don't-care and carry random junk.
    write_reg(REG_CARE_MASK, {junk[63:16], mask});
    write_reg(REG_PATTERN_LEN, {junk[63:LEN_BITS], len});
    cfg_valid <= 1'b0;
  endtask

  // One image: leading bytes, copies of the pattern with random wildcard bytes,
  // and trailing bytes. A corrupted image has one bit flipped in its first copy.
  task automatic send_image(input int lead, input int copies, input bit corrupt,
                            input int tail);
    byte_t img[$];
    int span;
    int c;
    int k;
    int pos;
    span = clamp_len(cur_len);
    repeat (lead) img.insert(img.size(), byte_t'($urandom));
    for (c = 0; c < copies; c++) begin
      for (k = 0; k < span; k++) begin
        img.insert(img.size(),
                   cur_mask[k] ? pattern_at(cur_low, cur_high, k) : byte_t'($urandom));
      end
      repeat ($urandom_range(3)) img.insert(img.size(), byte_t'($urandom));
    end
    if (corrupt && copies > 0) begin
      pos = lead + $urandom_range(span - 1);
      img[pos] = img[pos] ^ (8'h01 << $urandom_range(7));
    end
    repeat (tail) img.insert(img.size(), byte_t'($urandom));
    foreach (img[i]) send_byte(img[i], i == 0);
  endtask

  // Out of reset the mask is empty, so nothing may match.
  task automatic test_reset_state();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
  endtask

  // Full-length pattern with extreme bytes, matching at the restart byte.
  task automatic test_exact_pattern();
    configure(64'hFF00_8001_7FFE_00FF, 64'h0000_FFFF_A55A_0F0F, 16'hFFFF, 5'd16);
    send_image(0, 1, 1'b0, 0);
  endtask

  // The newest position matches on the first byte, but three bytes are needed.
  task automatic test_short_image();
    configure(64'h0000_0000_005A_0000, '1, 16'h0004, 5'd3);
    send_byte(8'h5A, 1'b1);
    send_byte(8'h11, 1'b0);
    send_byte(8'h5A, 1'b0);
  endtask

  // A length of zero behaves as one; the second hit is ignored.
  task automatic test_length_clamp();
    configure(64'h0000_0000_0000_00FF, '0, 16'h0001, 5'd0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
  endtask

  // Care bits that lie only beyond the length leave nothing to compare.
  task automatic test_no_care_position();
    configure({$urandom, $urandom}, {$urandom, $urandom}, 16'hFFF0, 5'd4);
    send_image(0, 1, 1'b0, 0);
  endtask

  task automatic test_random_scan();
    logic [15:0] mask;
    logic [LEN_BITS-1:0] len;
    logic [63:0] low;
    logic [63:0] high;
    int phase;
    int start;
    for (phase = 0; phase < SCAN_PHASES; phase++) begin
      case (phase * 3 / SCAN_PHASES)
        0: set_idle(24, 64);
        1: set_idle(64, 24);
        default: set_idle(0, 0);
      endcase
      if ($urandom_range(9) == 0) begin
        len = $urandom_range(1) ? 5'd0 : LEN_BITS'($urandom_range(31, 17));
      end else begin
        len = LEN_BITS'($urandom_range(16, 1));
      end
      case ($urandom_range(9))
        0: mask = 16'h0000;
        1: mask = 16'hFFFF;
        2: mask = 16'h0001 << $urandom_range(15);
        default: mask = 16'($urandom);
      endcase
      low = ($urandom_range(9) == 0) ? '1 : {$urandom, $urandom};
      high = ($urandom_range(9) == 0) ? '0 : {$urandom, $urandom};
      configure(low, high, mask, len);
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) begin
        case ($urandom_range(9))
          0, 1: begin
            repeat ($urandom_range(20, 4)) begin
              send_byte(byte_t'($urandom), $urandom_range(19) == 0);
            end
          end
          2: send_image($urandom_range(8), 1, 1'b1, $urandom_range(4));
          default: send_image($urandom_range(12), $urandom_range(2, 1), 1'b0,
                              $urandom_range(6));
        endcase
      end
    end
  endtask

  initial begin
    set_idle(24, 64);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_exact_pattern();
    test_short_image();
    test_length_clamp();
    test_no_care_position();
    test_random_scan();
    drain();
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_masked_byte_pattern_search_core passed");
    end else begin
      $display("tb_masked_byte_pattern_search_core failed");
    end
    $finish;
  end

endmodule
